### rtl/core/kli_pkg.sv
// Package for the keyframe linear interpolator core.
// Holds shared widths, action codes, reset values and the saturating add.
// Depends on nothing.
package kli_pkg;

  localparam int MAX_KEYFRAMES_DEF = 64;
  localparam int NCH = 4;
  localparam int POS_W = 32;
  localparam int STEP_W = 10;
  localparam int ACT_W = 2;
  localparam int FS_OUT_W = 7;
  localparam int KF_W = NCH * POS_W;

  localparam logic [STEP_W-1:0] STEPS_RESET = 10'd50;

  localparam logic [ACT_W-1:0] ACT_SAVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [POS_W:0] diff_t;

  function automatic pos_t sat_add(input pos_t a, input pos_t b);
    logic signed [POS_W:0] sum;
    pos_t res;
    sum = {a[POS_W-1], a} + {b[POS_W-1], b};
    if (sum[POS_W] != sum[POS_W-1]) begin
      res = sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/kli_if.sv
// Handshake interfaces for the keyframe interpolator item and result channels.
// Each carries valid, ready and the payload fields; no dependencies.
interface kli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] left_bar_in;
  logic signed [31:0] right_bar_in;
  logic signed [31:0] ball_x_in;
  logic signed [31:0] ball_y_in;

  modport source (output valid, action, left_bar_in, right_bar_in, ball_x_in, ball_y_in,
                  input ready);
  modport sink (input valid, action, left_bar_in, right_bar_in, ball_x_in, ball_y_in,
                output ready);
endinterface

interface kli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_bar_out;
  logic signed [31:0] right_bar_out;
  logic signed [31:0] ball_x_out;
  logic signed [31:0] ball_y_out;
  logic               playing;
  logic [6:0]         frames_stored;
  logic               save_refused;

  modport source (output valid, left_bar_out, right_bar_out, ball_x_out, ball_y_out,
                  playing, frames_stored, save_refused, input ready);
  modport sink (input valid, left_bar_out, right_bar_out, ball_x_out, ball_y_out,
                playing, frames_stored, save_refused, output ready);
endinterface

### rtl/core/kli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the keyframe store; no dependencies.
module kli_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kli_div.sv
// Radix-2 restoring divider for one channel's increment, one quotient bit per cycle.
// Divides a signed 33-bit difference by the step count and saturates; uses kli_pkg.
module kli_div
  import kli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  diff_t             dividend,
  input  logic [STEP_W-1:0] divisor,
  output logic              done,
  output pos_t              quotient
);

  localparam int ITER = POS_W + 1;
  localparam int CNT_W = $clog2(ITER + 1);

  logic              busy;
  logic              neg;
  logic [POS_W:0]    mag;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   trial_sub;
  logic              ge;

  assign trial = {rem, mag[POS_W]};
  assign ge = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= CNT_W'(ITER);
      neg <= dividend[POS_W];
      mag <= dividend[POS_W] ? (POS_W + 1)'(-dividend) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
      mag <= {mag[POS_W-1:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (mag[POS_W] || (mag[POS_W-1] && |mag[POS_W-2:0])) begin
        quotient = POS_MIN;
      end else begin
        quotient = -$signed(mag[POS_W-1:0]);
      end
    end else begin
      if (mag[POS_W] || mag[POS_W-1]) begin
        quotient = POS_MAX;
      end else begin
        quotient = $signed(mag[POS_W-1:0]);
      end
    end
  end

endmodule

### rtl/core/keyframe_linear_interpolator_core.sv
// Top level of the four-channel linear keyframe interpolator.
// Uses kli_pkg, kli_if, kli_ram and kli_div.
//
// Channel   Direction  Handshake    Contents
// item      in         valid/ready  action and four Q16.16 values to save
// result    out        valid/ready  four Q16.16 positions and status
// cfg       in         cfg_wr_en    steps_per_segment, no read-back
//
// Save, stop, idle tick and in-segment tick go from accept to S_FIN, then to the registered result.
// Play start and segment advance first do two store reads (S_RDA, S_RDB), then run the
// four parallel bit-serial dividers (S_DIVS, S_DIVW) before S_FIN.
// One item is in work at a time; the next is accepted while the result waits.
// Reset is synchronous; the keyframe store is not cleared and only written entries are read.
// A stalled result is held until taken; the next finished item waits in S_FIN meanwhile.
module keyframe_linear_interpolator_core
  import kli_pkg::*;
#(
  parameter int MAX_KEYFRAMES = MAX_KEYFRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data,
  kli_in_if.sink            item,
  kli_out_if.source         result
);

  localparam int CNT_W = $clog2(MAX_KEYFRAMES + 1);
  localparam int ADDR_W = $clog2(MAX_KEYFRAMES);
  localparam int FS_W = (CNT_W > FS_OUT_W) ? CNT_W : FS_OUT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        st;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] eff_steps;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] seg;
  logic [STEP_W-1:0] step_cnt;
  logic              play;
  logic              load_pos;
  logic              refused;
  pos_t              pos [NCH];
  pos_t              inc [NCH];
  logic [KF_W-1:0]   kf_a;

  logic              res_valid;
  pos_t              res_pos [NCH];
  logic              res_play;
  logic [FS_OUT_W-1:0] res_frames;
  logic              res_refused;

  logic              accept;
  logic              full;
  logic [ADDR_W:0]   seg_plus1;
  logic [CNT_W:0]    seg_plus2;
  logic              last_seg;
  logic              mem_we;
  logic [ADDR_W-1:0] raddr;
  logic [KF_W-1:0]   wdata;
  logic [KF_W-1:0]   rdata;
  logic [FS_W-1:0]   count_wide;
  logic              out_free;

  logic [NCH-1:0]    div_done;
  logic              div_start;
  pos_t              div_q [NCH];
  diff_t             div_d [NCH];

  assign eff_steps = (steps == '0) ? STEP_W'(1) : steps;
  assign accept = item.valid && item.ready;
  assign item.ready = (st == S_IDLE);
  assign full = (count >= CNT_W'(MAX_KEYFRAMES));
  assign seg_plus1 = {1'b0, seg} + 1'b1;
  assign seg_plus2 = (CNT_W + 1)'(seg_plus1) + 1'b1;
  assign last_seg = seg_plus2 >= {1'b0, count};
  assign mem_we = accept && (item.action == ACT_SAVE) && !full;
  assign wdata = {item.ball_y_in, item.ball_x_in, item.right_bar_in, item.left_bar_in};
  assign raddr = (st == S_RDB) ? seg_plus1[ADDR_W-1:0] : seg;
  assign div_start = (st == S_DIVS);
  assign count_wide = FS_W'(count);
  assign out_free = !res_valid || result.ready;

  kli_ram #(
    .WIDTH(KF_W),
    .DEPTH(MAX_KEYFRAMES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  for (genvar c = 0; c < NCH; c++) begin : g_div
    assign div_d[c] = {rdata[c*POS_W+POS_W-1], rdata[c*POS_W +: POS_W]}
                    - {kf_a[c*POS_W+POS_W-1], kf_a[c*POS_W +: POS_W]};
    kli_div u_div (
      .clk     (clk),
      .rst     (rst),
      .start   (div_start),
      .dividend(div_d[c]),
      .divisor (eff_steps),
      .done    (div_done[c]),
      .quotient(div_q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      steps <= STEPS_RESET;
      count <= '0;
      seg <= '0;
      step_cnt <= '0;
      play <= 1'b0;
      load_pos <= 1'b0;
      refused <= 1'b0;
      res_valid <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        pos[c] <= '0;
        inc[c] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        steps <= cfg_wr_data;
      end
      if (st == S_FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            refused <= (item.action == ACT_SAVE) && full;
            case (item.action)
              ACT_SAVE: begin
                st <= S_FIN;
                if (!full) begin
                  count <= count + 1'b1;
                end
              end
              ACT_PLAY: begin
                if (!play && count > CNT_W'(1)) begin
                  seg <= '0;
                  step_cnt <= '0;
                  play <= 1'b1;
                  load_pos <= 1'b1;
                  st <= S_RDA;
                end else begin
                  play <= 1'b0;
                  st <= S_FIN;
                end
              end
              ACT_TICK: begin
                if (play && step_cnt >= eff_steps && !last_seg) begin
                  seg <= seg_plus1[ADDR_W-1:0];
                  step_cnt <= '0;
                  load_pos <= 1'b0;
                  st <= S_RDA;
                end else begin
                  st <= S_FIN;
                  if (play) begin
                    if (step_cnt >= eff_steps) begin
                      seg <= '0;
                      play <= 1'b0;
                    end else begin
                      for (int c = 0; c < NCH; c++) begin
                        pos[c] <= sat_add(pos[c], inc[c]);
                      end
                      step_cnt <= step_cnt + 1'b1;
                    end
                  end
                end
              end
              default: begin
                st <= S_FIN;
              end
            endcase
          end
        end
        S_RDA: begin
          st <= S_RDB;
        end
        S_RDB: begin
          kf_a <= rdata;
          if (load_pos) begin
            for (int c = 0; c < NCH; c++) begin
              pos[c] <= rdata[c*POS_W +: POS_W];
            end
          end
          st <= S_DIVS;
        end
        S_DIVS: begin
          st <= S_DIVW;
        end
        S_DIVW: begin
          if (&div_done) begin
            for (int c = 0; c < NCH; c++) begin
              inc[c] <= div_q[c];
            end
            st <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FIN && out_free) begin
      for (int c = 0; c < NCH; c++) begin
        res_pos[c] <= pos[c];
      end
      res_play <= play;
      res_frames <= count_wide[FS_OUT_W-1:0];
      res_refused <= refused;
    end
  end

  assign result.valid = res_valid;
  assign result.left_bar_out = res_pos[0];
  assign result.right_bar_out = res_pos[1];
  assign result.ball_x_out = res_pos[2];
  assign result.ball_y_out = res_pos[3];
  assign result.playing = res_play;
  assign result.frames_stored = res_frames;
  assign result.save_refused = res_refused;

endmodule

### rtl/core/kli_checker.sv
// Port-level assertions for the keyframe interpolator core, with the bind that attaches them.
// Depends on keyframe_linear_interpolator_core and its interfaces.
module kli_checker #(
  parameter int MAX_KEYFRAMES = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_left_bar,
  input logic [6:0]         out_frames,
  input logic               out_refused
);

  localparam logic [6:0] FULL_FRAMES = 7'(MAX_KEYFRAMES % 128);

  logic [1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'((in_valid && in_ready) ? 1 : 0) - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_result_has_transaction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result shown with no accepted transaction outstanding");

  a_two_outstanding: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two transactions outstanding");

  a_refused_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_refused |-> out_frames == FULL_FRAMES)
    else $error("save refused while the store was not full");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_frames) && $stable(out_left_bar))
    else $error("stalled result changed");

endmodule

bind keyframe_linear_interpolator_core kli_checker #(
  .MAX_KEYFRAMES(MAX_KEYFRAMES)
) u_kli_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_left_bar(result.left_bar_out),
  .out_frames  (result.frames_stored),
  .out_refused (result.save_refused)
);

### tb/sv/keyframe_linear_interpolator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for keyframe_linear_interpolator_core: a directed table, then random
// phases at several step counts, each result compared with a table row or an animator model.
// Depends on kli_pkg, the kli_in_if and kli_out_if interfaces and the core RTL.
module keyframe_linear_interpolator_core_tb;
  import kli_pkg::*;

  localparam int KF_DEPTH = MAX_KEYFRAMES_DEF;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS = 230;
  localparam int NUM_PHASES = 7;
  localparam int SCRIPT_LEN = 21;

  typedef logic [0:NCH-1][POS_W-1:0] quad_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    quad_t            vals;
  } anim_cmd_t;

  typedef struct packed {
    quad_t               pos;
    logic                playing;
    logic [FS_OUT_W-1:0] stored;
    logic                refused;
  } anim_frame_t;

  typedef struct packed {
    anim_cmd_t   cmd;
    logic        typed;
    anim_frame_t want;
  } script_row_t;

  localparam quad_t ZERO4 = '0;
  localparam quad_t NOISE4 = '{POS_MAX, POS_MIN, POS_MAX, POS_MIN};
  localparam quad_t KF0 = '{POS_MAX - 1, POS_MIN + 1, 32'sd0, 32'sd1};
  localparam quad_t KF1 = '{POS_MAX - 4, POS_MIN + 4, -32'sd1, POS_MIN};
  localparam quad_t KF2 = '{POS_MAX, POS_MIN, POS_MAX, POS_MAX};
  localparam quad_t KF3 = '{POS_MIN, POS_MAX, 32'sh1234_5678, -32'sh0765_4321};

  // With two ticks per segment, the second segment overshoots and saturates on every channel
  // but ball y, because the first segment stops short of its target.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{ACT_TICK, NOISE4}, 1'b1, '{ZERO4, 1'b0, 7'd0, 1'b0}},
    '{'{ACT_PLAY, NOISE4}, 1'b1, '{ZERO4, 1'b0, 7'd0, 1'b0}},
    '{'{ACT_NONE, NOISE4}, 1'b1, '{ZERO4, 1'b0, 7'd0, 1'b0}},
    '{'{ACT_SAVE, KF0}, 1'b1, '{ZERO4, 1'b0, 7'd1, 1'b0}},
    '{'{ACT_PLAY, NOISE4}, 1'b1, '{ZERO4, 1'b0, 7'd1, 1'b0}},
    '{'{ACT_SAVE, KF1}, 1'b1, '{ZERO4, 1'b0, 7'd2, 1'b0}},
    '{'{ACT_SAVE, KF2}, 1'b1, '{ZERO4, 1'b0, 7'd3, 1'b0}},
    '{'{ACT_PLAY, NOISE4}, 1'b1, '{KF0, 1'b1, 7'd3, 1'b0}},
    '{'{ACT_TICK, NOISE4}, 1'b0, '0},
    '{'{ACT_TICK, ZERO4}, 1'b0, '0},
    '{'{ACT_TICK, NOISE4}, 1'b0, '0},
    '{'{ACT_TICK, ZERO4}, 1'b0, '0},
    '{'{ACT_TICK, NOISE4}, 1'b0, '0},
    '{'{ACT_TICK, ZERO4}, 1'b0, '0},
    '{'{ACT_TICK, NOISE4}, 1'b0, '0},
    '{'{ACT_PLAY, ZERO4}, 1'b1, '{KF0, 1'b1, 7'd3, 1'b0}},
    '{'{ACT_TICK, NOISE4}, 1'b0, '0},
    '{'{ACT_SAVE, KF3}, 1'b0, '0},
    '{'{ACT_PLAY, NOISE4}, 1'b0, '0},
    '{'{ACT_TICK, ZERO4}, 1'b0, '0},
    '{'{ACT_PLAY, NOISE4}, 1'b1, '{KF0, 1'b1, 7'd4, 1'b0}}
  };

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [STEP_W-1:0] cfg_wr_data;

  kli_in_if  item_bus ();
  kli_out_if result_bus ();

  keyframe_linear_interpolator_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_bus),
    .result      (result_bus)
  );

  pos_t              kf_store [KF_DEPTH][NCH];
  int unsigned       kf_count;
  pos_t              cur_pos [NCH];
  pos_t              cur_rate [NCH];
  int unsigned       seg_idx;
  logic [STEP_W-1:0] seg_step;
  logic              running;
  logic [STEP_W-1:0] steps_cfg;
  anim_frame_t       frames_due [$];

  string chan_names [NCH] = '{"left_bar_out", "right_bar_out", "ball_x_out", "ball_y_out"};

  int  idle_odds;
  bit  hold_request;
  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  refused_saves;
  int  playback_starts;
  int  seg_advances;
  int  clamped_adds;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pos_t clamp_q16(input longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return pos_t'(v);
  endfunction

  function automatic longint eff_span();
    return (steps_cfg == '0) ? 64'sd1 : longint'(steps_cfg);
  endfunction

  function automatic void load_rates();
    longint delta;
    for (int c = 0; c < NCH; c++) begin
      if (seg_idx + 1 >= KF_DEPTH) begin
        cur_rate[c] = '0;
      end else begin
        delta = longint'(kf_store[seg_idx + 1][c]) - longint'(kf_store[seg_idx][c]);
        cur_rate[c] = clamp_q16(delta / eff_span());
      end
    end
  endfunction

  function automatic anim_frame_t animate(input anim_cmd_t cmd);
    anim_frame_t f;
    longint      sum;
    f = '0;
    case (cmd.action)
      ACT_SAVE: begin
        if (kf_count < KF_DEPTH) begin
          for (int c = 0; c < NCH; c++) kf_store[kf_count][c] = pos_t'(cmd.vals[c]);
          kf_count++;
        end else begin
          f.refused = 1'b1;
          refused_saves++;
        end
      end
      ACT_PLAY: begin
        if (!running && kf_count > 1) begin
          for (int c = 0; c < NCH; c++) cur_pos[c] = kf_store[0][c];
          seg_idx = 0;
          load_rates();
          running = 1'b1;
          seg_step = '0;
          playback_starts++;
        end else begin
          running = 1'b0;
        end
      end
      ACT_TICK: begin
        if (running) begin
          if (longint'(seg_step) >= eff_span()) begin
            seg_idx++;
            if (seg_idx + 2 > kf_count) begin
              seg_idx = 0;
              running = 1'b0;
            end else begin
              seg_step = '0;
              load_rates();
              seg_advances++;
            end
          end else begin
            for (int c = 0; c < NCH; c++) begin
              sum = longint'(cur_pos[c]) + longint'(cur_rate[c]);
              if (sum > longint'(POS_MAX) || sum < longint'(POS_MIN)) clamped_adds++;
              cur_pos[c] = clamp_q16(sum);
            end
            seg_step = seg_step + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    for (int c = 0; c < NCH; c++) f.pos[c] = cur_pos[c];
    f.playing = running;
    f.stored = FS_OUT_W'(kf_count);
    return f;
  endfunction

  function automatic logic [POS_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3, 4: return $urandom_range(0, 4000) - 32'd2000;
      default: return $urandom();
    endcase
  endfunction

  function automatic anim_cmd_t random_cmd(input logic [ACT_W-1:0] act);
    anim_cmd_t cmd;
    cmd.action = act;
    for (int c = 0; c < NCH; c++) cmd.vals[c] = rand_q16();
    return cmd;
  endfunction

  function automatic void check_frame(input anim_frame_t got);
    anim_frame_t want;
    if (frames_due.size() == 0) begin
      $error("result transaction with no expected result pending");
      mismatches++;
      return;
    end
    want = frames_due.pop_front();
    results_checked++;
    for (int c = 0; c < NCH; c++) begin
      if (got.pos[c] !== want.pos[c]) begin
        $error("%s: expected %0d, actual %0d", chan_names[c], $signed(want.pos[c]),
               $signed(got.pos[c]));
        mismatches++;
      end
    end
    if (got.playing !== want.playing) begin
      $error("playing: expected %0d, actual %0d", want.playing, got.playing);
      mismatches++;
    end
    if (got.stored !== want.stored) begin
      $error("frames_stored: expected %0d, actual %0d", want.stored, got.stored);
      mismatches++;
    end
    if (got.refused !== want.refused) begin
      $error("save_refused: expected %0d, actual %0d", want.refused, got.refused);
      mismatches++;
    end
  endfunction

  // Returns at the edge where the transaction is accepted, with valid still high.
  task automatic issue_cmd(input anim_cmd_t cmd, input logic typed, input anim_frame_t want);
    anim_frame_t f;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.action <= cmd.action;
    item_bus.left_bar_in <= cmd.vals[0];
    item_bus.right_bar_in <= cmd.vals[1];
    item_bus.ball_x_in <= cmd.vals[2];
    item_bus.ball_y_in <= cmd.vals[3];
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    f = animate(cmd);
    frames_due.push_back(typed ? want : f);
    items_sent++;
  endtask

  task automatic set_steps(input logic [STEP_W-1:0] value);
    item_bus.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    steps_cfg = value;
  endtask

  task automatic run_random_phase(input int quota);
    int issued;
    int pick;
    int run_len;
    int full_len;
    issued = 0;
    while (issued < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if (!running || $urandom_range(0, 5) == 0) begin
          issue_cmd(random_cmd(ACT_PLAY), 1'b0, '0);
          issued++;
        end
        full_len = (kf_count > 1) ? int'((kf_count - 1) * (eff_span() + 1)) + 2 : 2;
        run_len = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0 && full_len <= 300) run_len = full_len;
        repeat (run_len) issue_cmd(random_cmd(ACT_TICK), 1'b0, '0);
        issued += run_len;
        if ($urandom_range(0, 3) == 0) begin
          issue_cmd(random_cmd(ACT_PLAY), 1'b0, '0);
          issued++;
        end
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 3)) begin
          issue_cmd(random_cmd(ACT_SAVE), 1'b0, '0);
          issued++;
        end
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 4)) begin
          issue_cmd(random_cmd(ACT_TICK), 1'b0, '0);
          issued++;
        end
      end else if (pick < 92) begin
        issue_cmd(random_cmd(ACT_NONE), 1'b0, '0);
      end else begin
        issue_cmd(random_cmd(ACT_PLAY), 1'b0, '0);
        issued++;
      end
    end
  endtask

  initial begin
    int          stall_left;
    int          hold_left;
    anim_frame_t got;
    stall_left = 0;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        got.pos[0] = result_bus.left_bar_out;
        got.pos[1] = result_bus.right_bar_out;
        got.pos[2] = result_bus.ball_x_out;
        got.pos[3] = result_bus.ball_y_out;
        got.playing = result_bus.playing;
        got.stored = result_bus.frames_stored;
        got.refused = result_bus.save_refused;
        check_frame(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(1, 11) - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [STEP_W-1:0] plan [NUM_PHASES];
    int                top_up;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    item_bus.valid <= 1'b0;
    item_bus.action <= ACT_NONE;
    item_bus.left_bar_in <= '0;
    item_bus.right_bar_in <= '0;
    item_bus.ball_x_in <= '0;
    item_bus.ball_y_in <= '0;
    idle_odds = 8;
    hold_request = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    refused_saves = 0;
    playback_starts = 0;
    seg_advances = 0;
    clamped_adds = 0;
    kf_count = 0;
    seg_idx = 0;
    seg_step = '0;
    running = 1'b0;
    steps_cfg = STEPS_RESET;
    for (int c = 0; c < NCH; c++) begin
      cur_pos[c] = '0;
      cur_rate[c] = '0;
    end
    plan[0] = 10'd0;
    plan[1] = 10'd1023;
    plan[2] = 10'd3;
    plan[3] = STEP_W'($urandom_range(1, 1023));
    plan[4] = 10'd1;
    plan[5] = STEP_W'($urandom_range(2, 12));
    plan[6] = 10'd5;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_steps(10'd2);
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      issue_cmd(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_steps(plan[p]);
      idle_odds = (p == NUM_PHASES - 1) ? 0 : $urandom_range(3, 12);
      if (p == 1) hold_request = 1'b1;
      if (p == 3) begin
        top_up = KF_DEPTH - int'(kf_count) + 2;
        repeat (top_up) issue_cmd(random_cmd(ACT_SAVE), 1'b0, '0);
      end
      run_random_phase(PHASE_ITEMS);
    end

    item_bus.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results over %0d step counts.",
             items_sent, results_checked, NUM_PHASES + 1);
    $display("Saw %0d playbacks, %0d segment changes, %0d saturated adds, %0d refused saves.",
             playback_starts, seg_advances, clamped_adds, refused_saves);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/kli_pkg.sv
rtl/core/kli_if.sv
rtl/core/kli_ram.sv
rtl/core/kli_div.sv
rtl/core/keyframe_linear_interpolator_core.sv
rtl/core/kli_checker.sv
tb/sv/keyframe_linear_interpolator_core_tb.sv
